@@ sv/pf_pkg.sv @@
// Shared types and the microcode program of the prime factorizer.
// Holds datapath op codes, jump conditions, the control word and the program ROM.
// No dependencies.
package pf_pkg;

    localparam int unsigned IN_W   = 16;
    localparam int unsigned FAC_W  = 16;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned TDATA_W = 24;
    localparam int unsigned PC_W   = 4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_EMIT_DIV,
        OP_STEP_D,
        OP_EMIT_Q,
        OP_EMIT_EMPTY
    } t_dp_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_NONE,
        C_Q_LT2,
        C_SQ_GT_Q,
        C_DIV_BUSY,
        C_REM_NZ,
        C_DONE
    } t_cond;

    typedef struct packed {
        t_dp_op          op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_none;
        logic q_lt2;
        logic sq_gt_q;
        logic div_busy;
        logic rem_nz;
        logic done;
        logic out_busy;
    } t_flags;

    localparam logic [PC_W-1:0] A_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] A_SMALL = 4'd1;
    localparam logic [PC_W-1:0] A_LOOP  = 4'd2;
    localparam logic [PC_W-1:0] A_DSTRT = 4'd3;
    localparam logic [PC_W-1:0] A_DWAIT = 4'd4;
    localparam logic [PC_W-1:0] A_TEST  = 4'd5;
    localparam logic [PC_W-1:0] A_EMITF = 4'd6;
    localparam logic [PC_W-1:0] A_BACK  = 4'd7;
    localparam logic [PC_W-1:0] A_NEXTD = 4'd8;
    localparam logic [PC_W-1:0] A_TAIL  = 4'd9;
    localparam logic [PC_W-1:0] A_EMPTY = 4'd10;

    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_WAIT};
        case (pc)
            A_WAIT:  w = '{op: OP_LOAD,       cond: C_IN_NONE,  target: A_WAIT};
            A_SMALL: w = '{op: OP_NOP,        cond: C_Q_LT2,    target: A_EMPTY};
            A_LOOP:  w = '{op: OP_NOP,        cond: C_SQ_GT_Q,  target: A_TAIL};
            A_DSTRT: w = '{op: OP_DIV_START,  cond: C_NEVER,    target: A_WAIT};
            A_DWAIT: w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: A_DWAIT};
            A_TEST:  w = '{op: OP_NOP,        cond: C_REM_NZ,   target: A_NEXTD};
            A_EMITF: w = '{op: OP_EMIT_DIV,   cond: C_DONE,     target: A_WAIT};
            A_BACK:  w = '{op: OP_NOP,        cond: C_ALWAYS,   target: A_LOOP};
            A_NEXTD: w = '{op: OP_STEP_D,     cond: C_ALWAYS,   target: A_LOOP};
            A_TAIL:  w = '{op: OP_EMIT_Q,     cond: C_ALWAYS,   target: A_WAIT};
            A_EMPTY: w = '{op: OP_EMIT_EMPTY, cond: C_ALWAYS,   target: A_WAIT};
            default: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: A_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ sv/pf_div.sv @@
// Restoring divider: one quotient bit per cycle.
// Depends on nothing outside this file.
module pf_div #(
    parameter int unsigned DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [DW:0]   rem_sh;
    logic          ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // shift in the next dividend bit, subtract when it fits
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? DW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ sv/pf_seq.sv @@
// Microcode sequencer: step counter, program ROM fetch and conditional jumps.
// Depends on pf_pkg for the control word, op codes and status flags.
module pf_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pf_pkg::t_flags  i_flags,
    output pf_pkg::t_dp_op  o_op,
    output logic            o_exec
);

    logic [pf_pkg::PC_W-1:0] r_pc;
    logic [pf_pkg::PC_W-1:0] n_pc;
    pf_pkg::t_uword          uw;
    logic                    is_emit;
    logic                    hold;
    logic                    take;

    assign uw = pf_pkg::ucode_rom(r_pc);

    always_comb begin
        is_emit = (uw.op == pf_pkg::OP_EMIT_DIV) || (uw.op == pf_pkg::OP_EMIT_Q) ||
                  (uw.op == pf_pkg::OP_EMIT_EMPTY);
        // hold an emit step while the output register is occupied
        hold = is_emit && i_flags.out_busy;
        unique case (uw.cond)
            pf_pkg::C_NEVER:    take = 1'b0;
            pf_pkg::C_ALWAYS:   take = 1'b1;
            pf_pkg::C_IN_NONE:  take = i_flags.in_none;
            pf_pkg::C_Q_LT2:    take = i_flags.q_lt2;
            pf_pkg::C_SQ_GT_Q:  take = i_flags.sq_gt_q;
            pf_pkg::C_DIV_BUSY: take = i_flags.div_busy;
            pf_pkg::C_REM_NZ:   take = i_flags.rem_nz;
            pf_pkg::C_DONE:     take = i_flags.done;
            default:            take = 1'b0;
        endcase
        if (hold) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pf_pkg::A_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op   = uw.op;
    assign o_exec = !hold;

endmodule

@@ sv/prime_factorizer.sv @@
// Trial-division prime factorizer: a number in, its prime factors out in ascending order.
// Each trial divisor runs one division on the bit-serial divider; divisors are tried
// in turn until the divisor squared exceeds what is left of the number, and inputs
// below 2 give an empty result without any division.
// One item at a time; the next input transfers once the last result is in the output register.
// Synchronous active-low reset returns the sequencer to its wait step and empties the output.
module prime_factorizer #(
    parameter int unsigned WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [pf_pkg::IN_W-1:0]     i_s_tdata,   // [15:0] number_in
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [pf_pkg::TDATA_W-1:0]  o_m_tdata,   // [15:0] prime_factor, [19:16] factor_position
    output logic                        o_m_tlast,   // is_last
    output logic                        o_m_tuser    // [0] is_empty
);

    localparam int unsigned DW = WIDTH;

    pf_pkg::t_dp_op op;
    logic           exec;
    pf_pkg::t_flags flags;

    logic [DW-1:0]   r_q;
    logic [DW-1:0]   r_d;
    logic [DW+1:0]   r_sq;
    logic [pf_pkg::POS_W-1:0] r_k;

    logic            div_busy;
    logic [DW-1:0]   div_quot;
    logic [DW-1:0]   div_rem;
    logic            div_start;
    logic            done;
    logic            in_xfer;
    logic            emit;

    logic                     r_out_valid;
    logic [pf_pkg::FAC_W-1:0] r_out_fac;
    logic [pf_pkg::POS_W-1:0] r_out_pos;
    logic                     r_out_last;
    logic                     r_out_empty;
    logic [pf_pkg::FAC_W-1:0] n_out_fac;
    logic                     n_out_last;
    logic                     n_out_empty;

    pf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op),
        .o_exec  (exec)
    );

    pf_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_q),
        .i_divisor  (r_d),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_s_tready = (op == pf_pkg::OP_LOAD);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign div_start  = exec && (op == pf_pkg::OP_DIV_START);
    // a found factor is final when nothing is left or the list is full
    assign done       = (div_quot == DW'(1)) || (r_k == {pf_pkg::POS_W{1'b1}});

    always_comb begin
        flags.in_none  = !i_s_tvalid;
        flags.q_lt2    = r_q < DW'(2);
        flags.sq_gt_q  = r_sq > {2'b00, r_q};
        flags.div_busy = div_busy;
        flags.rem_nz   = div_rem != '0;
        flags.done     = done;
        flags.out_busy = r_out_valid && !i_m_tready;
    end

    always_comb begin
        emit        = 1'b0;
        n_out_fac   = '0;
        n_out_last  = 1'b1;
        n_out_empty = 1'b0;
        case (op)
            pf_pkg::OP_EMIT_DIV: begin
                emit       = exec;
                n_out_fac  = pf_pkg::FAC_W'(r_d);
                n_out_last = done;
            end
            pf_pkg::OP_EMIT_Q: begin
                emit      = exec;
                n_out_fac = pf_pkg::FAC_W'(r_q);
            end
            pf_pkg::OP_EMIT_EMPTY: begin
                emit        = exec;
                n_out_empty = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // working registers of the datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_q  <= DW'(i_s_tdata);
            r_d  <= DW'(2);
            r_sq <= (DW+2)'(4);
            r_k  <= '0;
        end else if (exec && op == pf_pkg::OP_EMIT_DIV) begin
            r_q <= div_quot;
            r_k <= r_k + 1'b1;
        end else if (exec && op == pf_pkg::OP_EMIT_Q) begin
            r_k <= r_k + 1'b1;
        end else if (exec && op == pf_pkg::OP_STEP_D) begin
            if (r_d == DW'(2)) begin
                r_d  <= DW'(3);
                r_sq <= (DW+2)'(9);
            end else begin
                // (d+2)^2 = d^2 + 4d + 4
                r_d  <= r_d + DW'(2);
                r_sq <= r_sq + {r_d, 2'b00} + (DW+2)'(4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_fac   <= n_out_fac;
            r_out_pos   <= (op == pf_pkg::OP_EMIT_EMPTY) ? '0 : r_k;
            r_out_last  <= n_out_last;
            r_out_empty <= n_out_empty;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_pos, r_out_fac};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_empty;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata[15:0] == 16'd0))
        else $error("empty result not marked last or carries a factor");

    a_factor_ge2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[15:0] >= 16'd2)
        else $error("factor below two");

    a_idle_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !div_busy)
        else $error("input offered while divider busy");

    a_div_done_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

endmodule
